FILE: hdl/scq_pkg.sv
// Shared types, scancode constants and set-1 translation tables for the
// scancode queue. No dependencies; every other file but scq_ram imports it.
`default_nettype none

package scq_pkg;

    // Command codes on the request port
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_UNUSED = 2'd3
    } scq_cmd_t;

    // Classified operation handed from the front part to the back part
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2,
        OP_PEEK = 2'd3
    } scq_op_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] scancode;
        logic       data_ready;
        logic [7:0] peek_index;
    } scq_in_t;

    typedef struct packed {
        logic [7:0] ascii_code;
        logic [7:0] raw_code;
        logic       was_empty;
        logic       shift_held;
    } scq_out_t;

    typedef struct packed {
        scq_op_t    op;
        logic [7:0] scancode;
        logic [7:0] peek_index;
    } scq_req_t;

    typedef struct packed {
        logic [7:0] ascii;
        logic       shift;
    } scq_xlat_t;

    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_BREAK     = 8'h80;
    localparam logic [7:0] SC_TABLE_LEN = 8'h48;
    localparam logic [7:0] SC_PASS_MAX  = 8'h50;
    localparam int         TABLE_LEN    = 72;

    localparam logic [7:0] PLAIN_MAP [0:TABLE_LEN-1] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFT_MAP [0:TABLE_LEN-1] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Map one set-1 code to ASCII and track make/break of either shift key
    function automatic scq_xlat_t scq_translate(input logic [7:0] code,
                                                input logic       shift_in);
        scq_xlat_t res;
        res.ascii = 8'h00;
        res.shift = shift_in;
        if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            res.shift = 1'b1;
        end else if (code == (SC_LSHIFT | SC_BREAK) || code == (SC_RSHIFT | SC_BREAK)) begin
            res.shift = 1'b0;
        end else if (code < SC_TABLE_LEN) begin
            res.ascii = shift_in ? SHIFT_MAP[code[6:0]] : PLAIN_MAP[code[6:0]];
        end else if (code <= SC_PASS_MAX) begin
            res.ascii = code;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/scq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module scq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/scq_fifo.sv
// Two-entry queue of classified requests between front and back parts.
// Depends on scq_pkg.
`default_nettype none

module scq_fifo
    import scq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire scq_req_t push_req,
    input  wire logic     pop,
    output logic          empty,
    output logic          full,
    output scq_req_t      head
);

    scq_req_t   entry_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/scq_front.sv
// Front part: takes requests, classifies them into queue operations and
// tracks the request in flight. Depends on scq_pkg.
`default_nettype none

module scq_front
    import scq_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire scq_in_t request,
    input  wire logic    clearing,
    input  wire logic    done,
    output logic         busy,
    output logic         push,
    output scq_req_t     push_req
);

    logic     inflight_reg, inflight_next;
    logic     push_reg, push_next;
    scq_req_t req_reg, req_next;
    logic     accept;

    assign busy     = clearing || inflight_reg;
    assign accept   = start && !busy;
    assign push     = push_reg;
    assign push_req = req_reg;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept)
        begin
            inflight_next = 1'b1;
        end
        else if (done)
        begin
            inflight_next = 1'b0;
        end

        push_next           = accept;
        req_next            = req_reg;
        req_next.scancode   = request.scancode;
        req_next.peek_index = request.peek_index;
        case (request.command)
            CMD_PUSH:   req_next.op = request.data_ready ? OP_PUSH : OP_NONE;
            CMD_POP:    req_next.op = OP_POP;
            // a slot past the end reads as zero, same as an unused command
            CMD_PEEK:   req_next.op = (32'(request.peek_index) < BUFFER_DEPTH) ?
                                      OP_PEEK : OP_NONE;
            default:    req_next.op = OP_NONE;
        endcase
        if (!accept)
        begin
            req_next = req_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 1'b0;
            push_reg     <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            push_reg     <= push_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

endmodule

`default_nettype wire

FILE: hdl/scq_back.sv
// Back part: owns the scancode ring, its positions and the shift flag,
// clears the ring after reset and builds each result. Depends on scq_pkg
// and scq_ram.
`default_nettype none

module scq_back
    import scq_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_empty,
    input  wire scq_req_t q_head,
    output logic          q_pop,
    output logic          clearing,
    output logic          done,
    output scq_out_t      result
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int PW = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

    state_t          state_reg, state_next;
    scq_op_t         op_reg, op_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0]   wr_pos_reg, wr_pos_next;
    logic [PW-1:0]   rd_pos_reg, rd_pos_next;
    logic            shift_reg, shift_next;
    logic            done_reg, done_next;
    scq_out_t        result_reg, result_next;

    logic [PW-1:0]   wr_eff, rd_eff;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata, mem_rdata;
    scq_xlat_t       xlat;

    scq_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // positions run up to the depth and wrap just before use
    assign wr_eff   = (wr_pos_reg == PW'(BUFFER_DEPTH)) ? '0 : wr_pos_reg;
    assign rd_eff   = (rd_pos_reg == PW'(BUFFER_DEPTH)) ? '0 : rd_pos_reg;
    assign xlat     = scq_translate(mem_rdata, shift_reg);
    assign clearing = (state_reg == ST_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        clr_cnt_next = clr_cnt_reg;
        wr_pos_next  = wr_pos_reg;
        rd_pos_next  = rd_pos_reg;
        shift_next   = shift_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = wr_eff[AW-1:0];
        mem_wdata    = q_head.scancode;
        mem_re       = 1'b0;
        mem_raddr    = rd_eff[AW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 8'h00;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(BUFFER_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    result_next = '{ascii_code: 8'h00, raw_code: 8'h00,
                                    was_empty: 1'b0, shift_held: shift_reg};
                    case (q_head.op)
                        OP_PUSH:
                        begin
                            mem_we      = 1'b1;
                            wr_pos_next = wr_eff + 1'b1;
                            done_next   = 1'b1;
                        end
                        OP_POP:
                        begin
                            if (rd_pos_reg != wr_pos_reg)
                            begin
                                mem_re      = 1'b1;
                                rd_pos_next = rd_eff + 1'b1;
                                op_next     = OP_POP;
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                result_next.was_empty = 1'b1;
                                done_next             = 1'b1;
                            end
                        end
                        OP_PEEK:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(q_head.peek_index);
                            op_next    = OP_PEEK;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                done_next            = 1'b1;
                state_next           = ST_IDLE;
                result_next.raw_code = mem_rdata;
                if (op_reg == OP_POP)
                begin
                    shift_next             = xlat.shift;
                    result_next.ascii_code = xlat.ascii;
                    result_next.shift_held = xlat.shift;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            op_reg      <= OP_NONE;
            clr_cnt_reg <= '0;
            wr_pos_reg  <= '0;
            rd_pos_reg  <= '0;
            shift_reg   <= 1'b0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            clr_cnt_reg <= clr_cnt_next;
            wr_pos_reg  <= wr_pos_next;
            rd_pos_reg  <= rd_pos_next;
            shift_reg   <= shift_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/scancode_queue_to_ascii.sv
// Top level of the keyboard scancode queue with set-1 to ASCII translation.
// Depends on scq_pkg, scq_front, scq_fifo, scq_back and scq_ram.
//
// A request is taken on a clock edge where start is high and busy is low;
// busy then stays high until its result has been shown. Each request gives
// exactly one result, held on result for the single cycle in which done is
// high; the receiver must take it then, as there is no way to hold it off.
// A request passes from the front part's request register through the
// two-entry queue to the back part; a pop that finds data and an in-range
// peek also pass through ST_READ for the registered read of the scancode
// RAM. The next request can be taken in the cycle after the edge that
// takes its result. After reset the block clears its BUFFER_DEPTH-entry
// RAM, one entry per cycle, holding busy high meanwhile. Pushes past the
// buffer size overwrite unread entries with no warning.
`default_nettype none

module scancode_queue_to_ascii
    import scq_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire scq_in_t request,
    output logic         busy,
    output logic         done,
    output scq_out_t     result
);

    logic     clearing;
    logic     push;
    scq_req_t push_req;
    logic     q_pop, q_empty, q_full;
    scq_req_t q_head;

    scq_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .clearing (clearing),
        .done     (done),
        .busy     (busy),
        .push     (push),
        .push_req (push_req)
    );

    // one request in flight never fills the queue
    scq_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push && !q_full),
        .push_req (push_req),
        .pop      (q_pop),
        .empty    (q_empty),
        .full     (q_full),
        .head     (q_head)
    );

    scq_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

FILE: verif/tb_scancode_queue_to_ascii.sv
// Testbench for scancode_queue_to_ascii: drives push, pop and peek requests
// through the start/busy handshake and checks every done strobe against a
// built-in predictor of the ring buffer and set-1 translation. Needs scq_pkg.
`default_nettype none

module tb_scancode_queue_to_ascii;
    import scq_pkg::*;

    localparam int QUEUE_DEPTH  = 256;
    localparam int TARGET_ITEMS = 750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTED  = 40;

    // Predicts the queue and shift state and matches results in order
    class scancode_scoreboard;
        logic [7:0]  codes [QUEUE_DEPTH];
        logic [7:0]  plain_tab [TABLE_LEN];
        logic [7:0]  shifted_tab [TABLE_LEN];
        int unsigned wr_pos;
        int unsigned rd_pos;
        bit          shift_on;
        scq_out_t    expected_q [$];
        int          fail_count;
        int          pops;
        int          empty_pops;
        int          peeks;
        int          wraps;

        function new();
            string pl [4] = '{"1234567890-=", "qwertyuiop[]", "asdfghjkl;'",
                              "\\zxcvbnm,./"};
            string sh [4] = '{"!@#$%^&*()_+", "QWERTYUIOP{}", "ASDFGHJKL:\"",
                              "|ZXCVBNM<>?"};
            int    base [4] = '{'h02, 'h10, 'h1E, 'h2B};
            foreach (codes[i]) codes[i] = 8'h00;
            foreach (plain_tab[i]) begin
                plain_tab[i]   = 8'h00;
                shifted_tab[i] = 8'h00;
            end
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < pl[r].len(); c++) begin
                    plain_tab[base[r] + c]   = pl[r][c];
                    shifted_tab[base[r] + c] = sh[r][c];
                end
            end
            // grave accent and tilde share one key
            plain_tab['h29] = 8'h60; shifted_tab['h29] = 8'h7E;
            plain_tab['h0E] = 8'h08; shifted_tab['h0E] = 8'h08;
            plain_tab['h0F] = 8'h09; shifted_tab['h0F] = 8'h09;
            plain_tab['h1C] = 8'h0A; shifted_tab['h1C] = 8'h0A;
            plain_tab['h37] = "*";   shifted_tab['h37] = "*";
            plain_tab['h39] = " ";   shifted_tab['h39] = " ";
            wr_pos   = 0;
            rd_pos   = 0;
            shift_on = 1'b0;
        endfunction

        function logic [7:0] to_ascii(logic [7:0] code);
            if (code == SC_LSHIFT || code == SC_RSHIFT) begin
                shift_on = 1'b1;
                return 8'h00;
            end
            if (code == (SC_LSHIFT | SC_BREAK) || code == (SC_RSHIFT | SC_BREAK)) begin
                shift_on = 1'b0;
                return 8'h00;
            end
            if (code < SC_TABLE_LEN)
                return shift_on ? shifted_tab[code] : plain_tab[code];
            if (code <= SC_PASS_MAX)
                return code;
            return 8'h00;
        endfunction

        // Entries a run of pops would return before the queue reads empty
        function int unsigned level();
            return (rd_pos <= wr_pos) ? wr_pos - rd_pos : QUEUE_DEPTH - rd_pos + wr_pos;
        endfunction

        function void note(scq_in_t req);
            scq_out_t exp_res;
            exp_res = '0;
            case (req.command)
                CMD_PUSH: begin
                    if (req.data_ready) begin
                        if (wr_pos >= QUEUE_DEPTH) begin
                            wr_pos = 0;
                            wraps++;
                        end
                        codes[wr_pos] = req.scancode;
                        wr_pos++;
                    end
                end
                CMD_POP: begin
                    pops++;
                    if (rd_pos != wr_pos) begin
                        if (rd_pos >= QUEUE_DEPTH)
                            rd_pos = 0;
                        exp_res.raw_code = codes[rd_pos];
                        rd_pos++;
                    end else begin
                        exp_res.was_empty = 1'b1;
                        empty_pops++;
                    end
                    exp_res.ascii_code = to_ascii(exp_res.raw_code);
                end
                CMD_PEEK: begin
                    peeks++;
                    if (req.peek_index < QUEUE_DEPTH)
                        exp_res.raw_code = codes[req.peek_index];
                end
                default: ;
            endcase
            exp_res.shift_held = shift_on;
            expected_q.push_back(exp_res);
        endfunction

        task report(string msg);
            fail_count++;
            if (fail_count <= MAX_PRINTED)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check(scq_out_t got);
            scq_out_t exp_res;
            if (expected_q.size() == 0) begin
                report($sformatf("result %h with no request outstanding", got));
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.ascii_code !== exp_res.ascii_code)
                report($sformatf("ascii_code %h, expected %h",
                                 got.ascii_code, exp_res.ascii_code));
            if (got.raw_code !== exp_res.raw_code)
                report($sformatf("raw_code %h, expected %h", got.raw_code, exp_res.raw_code));
            if (got.was_empty !== exp_res.was_empty)
                report($sformatf("was_empty %b, expected %b",
                                 got.was_empty, exp_res.was_empty));
            if (got.shift_held !== exp_res.shift_held)
                report($sformatf("shift_held %b, expected %b",
                                 got.shift_held, exp_res.shift_held));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    scq_in_t  request;
    logic     busy;
    logic     done;
    scq_out_t result;

    scancode_scoreboard sb;
    int unsigned cycle_count = 0;
    int          useful_items = 0;
    bit          no_idle = 1'b0;

    scancode_queue_to_ascii #(
        .BUFFER_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && done)
            sb.check(result);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic scq_in_t mk(scq_cmd_t cmd, logic [7:0] code, logic rdy,
                                   logic [7:0] idx);
        scq_in_t r;
        r.command    = cmd;
        r.scancode   = code;
        r.data_ready = rdy;
        r.peek_index = idx;
        return r;
    endfunction

    // Bias codes toward shift make/break, table entries and pass-through keys
    function automatic logic [7:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            case ($urandom_range(0, 3))
                0: return SC_LSHIFT;
                1: return SC_RSHIFT;
                2: return SC_LSHIFT | SC_BREAK;
                default: return SC_RSHIFT | SC_BREAK;
            endcase
        end
        if (r < 60)
            return 8'($urandom_range(0, SC_TABLE_LEN - 1));
        if (r < 75)
            return 8'($urandom_range(SC_TABLE_LEN, SC_PASS_MAX));
        return 8'($urandom);
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send(scq_in_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note(req);
        if (!(req.command == CMD_UNUSED || (req.command == CMD_PUSH && !req.data_ready)))
            useful_items++;
    endtask

    task automatic push_code(logic [7:0] code, logic rdy);
        send(mk(CMD_PUSH, code, rdy, 8'($urandom)));
    endtask

    task automatic pop_code();
        send(mk(CMD_POP, 8'($urandom), 1'($urandom), 8'($urandom)));
    endtask

    task automatic peek_at(logic [7:0] idx);
        send(mk(CMD_PEEK, 8'($urandom), 1'($urandom), idx));
    endtask

    initial
    begin
        logic [7:0] directed_codes [10];
        bit overflow_done;
        int n;
        int kind;

        directed_codes = '{8'h00, 8'hFF, 8'h2A, 8'h1E, 8'hAA,
                           8'h36, 8'h48, 8'h50, 8'h51, 8'hB6};
        sb = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        overflow_done = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, cleared store, ignored requests, shift make/break
        pop_code();
        peek_at(8'h00);
        push_code(8'h1E, 1'b0);
        send(mk(CMD_UNUSED, 8'hFF, 1'b1, 8'hFF));
        foreach (directed_codes[i])
            push_code(directed_codes[i], 1'b1);
        peek_at(8'hFF);
        repeat (11) pop_code();

        while (useful_items < TARGET_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            kind    = $urandom_range(0, 99);
            if (!overflow_done && useful_items > 300) begin
                // Overrun the ring so unread entries get overwritten
                overflow_done = 1'b1;
                repeat (QUEUE_DEPTH + $urandom_range(1, 6))
                    push_code(pick_code(), 1'b1);
                repeat ($urandom_range(3, 8)) pop_code();
            end else if (kind < 60) begin
                n = $urandom_range(1, 10);
                repeat (n) push_code(pick_code(), $urandom_range(0, 9) != 0);
                repeat ($urandom_range(1, n + 2)) begin
                    if ($urandom_range(0, 5) == 0)
                        peek_at(8'($urandom));
                    pop_code();
                end
            end else if (kind < 75) begin
                repeat ($urandom_range(1, 4)) peek_at(8'($urandom));
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 6)) send(scq_in_t'($urandom));
            end else begin
                repeat (sb.level() + $urandom_range(0, 2)) pop_code();
            end
        end
        start <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("covered %0d useful requests: %0d pops (%0d on an empty queue), %0d peeks",
                 useful_items, sb.pops, sb.empty_pops, sb.peeks);
        $display("write pointer wrapped %0d times, %0d mismatches", sb.wraps, sb.fail_count);
        if (sb.fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
